>>> hdl/tpr_pkg.sv
// tpr_pkg: shared types, constants and helpers for the time punch record parser
// used by tpr_step, tpr_res_fifo and time_punch_record_parser_top
`timescale 1ns / 1ps

package tpr_pkg;

    // status codes of a finished line
    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_BAD_SETTING = 4'd1,
        ST_COMMENT     = 4'd2,
        ST_LENGTH      = 4'd3,
        ST_IN_OUT      = 4'd4,
        ST_DATE_SEP    = 4'd5,
        ST_SPACES      = 4'd6,
        ST_CONVERSION  = 4'd7,
        ST_RANGE       = 4'd8,
        ST_TIME_SEP    = 4'd9,
        ST_NEWLINE     = 4'd10
    } status_t;

    // configuration register indexes (address bit 2)
    localparam logic REG_DATE_SEP = 1'b0;
    localparam logic REG_TIME_SEP = 1'b1;

    localparam logic [7:0] DATE_SEP_RESET = 8'd47;
    localparam logic [7:0] TIME_SEP_RESET = 8'd58;

    // characters of the record layout
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // line layout
    localparam logic [4:0] POS_MAX      = 5'd31;
    localparam logic [4:0] POS_LAST_LF  = 5'd29;
    localparam logic [4:0] POS_LAST_CRLF = 5'd30;
    localparam logic [2:0] BLANK_ALL    = 3'd4;

    // field limits
    localparam logic [13:0] MONTH_MIN   = 14'd1;
    localparam logic [13:0] MONTH_MAX   = 14'd12;
    localparam logic [13:0] DAY_MIN     = 14'd1;
    localparam logic [13:0] DAY_MAX     = 14'd31;
    localparam logic [13:0] YEAR_MIN    = 14'd1900;
    localparam logic [13:0] YEAR_MAX    = 14'd2200;
    localparam logic [13:0] COMMENT_MIN = 14'd1000;
    localparam logic [13:0] COMMENT_MAX = 14'd9999;
    localparam logic [13:0] HOUR_MAX    = 14'd23;
    localparam logic [13:0] MINUTE_MAX  = 14'd59;

    // per-line parser state
    typedef struct packed {
        logic [4:0]  position;
        status_t     first_error;
        logic        hash_seen;
        logic        out_flag;
        logic [13:0] acc;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [11:0] year;
        logic [13:0] comment;
        logic [4:0]  hour;
        logic [2:0]  blank_count;
        logic        cr_seen;
    } line_state_t;

    // one result item, status in the lowest bits
    typedef struct packed {
        logic [5:0]  minute_value;
        logic [4:0]  hour_value;
        logic [13:0] comment_number;
        logic [11:0] year_value;
        logic [4:0]  day_value;
        logic [3:0]  month_value;
        logic        punch_out;
        status_t     status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    function automatic logic out_of_range(input logic [13:0] v, input logic [13:0] lo,
                                          input logic [13:0] hi);
        out_of_range = (v < lo) || (v > hi);
    endfunction

endpackage

>>> hdl/tpr_step.sv
// tpr_step: combinational update of the line state for one byte, plus the line result
// depends on tpr_pkg
`timescale 1ns / 1ps

module tpr_step
(
    input  tpr_pkg::line_state_t state,
    input  logic [7:0]           char_byte,
    input  logic [7:0]           date_sep,
    input  logic [7:0]           time_sep,
    output tpr_pkg::line_state_t state_next,
    output tpr_pkg::result_t     result
);

    logic            is_digit;
    logic [3:0]      digit;
    logic [16:0]     acc_x10_full;
    logic [13:0]     acc_x10;
    logic [13:0]     acc_cont;
    logic [13:0]     acc_first;
    tpr_pkg::status_t err;
    tpr_pkg::status_t fe_next;
    tpr_pkg::status_t st;

    // digit decode and multiply-by-ten accumulate
    assign is_digit     = (char_byte >= tpr_pkg::CH_ZERO) && (char_byte <= tpr_pkg::CH_NINE);
    assign digit        = is_digit ? char_byte[3:0] : 4'd0;
    assign acc_x10_full = {state.acc, 3'b000} + {2'b00, state.acc, 1'b0};
    assign acc_x10      = acc_x10_full[13:0];
    assign acc_cont     = acc_x10 + {10'd0, digit};
    assign acc_first    = {10'd0, digit};

    // per-position checks
    always_comb
    begin
        state_next = state;
        err        = tpr_pkg::ST_OK;
        case (state.position)
            5'd0:
            begin
                state_next.hash_seen = (char_byte == tpr_pkg::CH_HASH);
                if (char_byte == tpr_pkg::CH_I)
                    state_next.out_flag = 1'b0;
                else if (char_byte == tpr_pkg::CH_O)
                    state_next.out_flag = 1'b1;
                else
                    err = tpr_pkg::ST_IN_OUT;
            end
            5'd1:
            begin
                if (char_byte != (state.out_flag ? tpr_pkg::CH_U : tpr_pkg::CH_N))
                    err = tpr_pkg::ST_IN_OUT;
            end
            5'd2:
            begin
                if (char_byte != (state.out_flag ? tpr_pkg::CH_T : tpr_pkg::CH_SPACE))
                    err = tpr_pkg::ST_IN_OUT;
            end
            5'd3, 5'd4, 5'd5:
            begin
                if (char_byte != tpr_pkg::CH_SPACE)
                    err = tpr_pkg::ST_IN_OUT;
            end
            5'd6, 5'd9, 5'd12, 5'd24, 5'd27:
            begin
                state_next.acc = acc_first;
                if (!is_digit)
                    err = tpr_pkg::ST_CONVERSION;
            end
            5'd13, 5'd14:
            begin
                state_next.acc = acc_cont;
                if (!is_digit)
                    err = tpr_pkg::ST_CONVERSION;
            end
            5'd7:
            begin
                state_next.acc   = acc_cont;
                state_next.month = acc_cont[3:0];
                if (!is_digit)
                    err = tpr_pkg::ST_CONVERSION;
                else if (tpr_pkg::out_of_range(acc_cont, tpr_pkg::MONTH_MIN, tpr_pkg::MONTH_MAX))
                    err = tpr_pkg::ST_RANGE;
            end
            5'd8, 5'd11:
            begin
                if (char_byte != date_sep)
                    err = tpr_pkg::ST_DATE_SEP;
            end
            5'd10:
            begin
                state_next.acc = acc_cont;
                state_next.day = acc_cont[4:0];
                if (!is_digit)
                    err = tpr_pkg::ST_CONVERSION;
                else if (tpr_pkg::out_of_range(acc_cont, tpr_pkg::DAY_MIN, tpr_pkg::DAY_MAX))
                    err = tpr_pkg::ST_RANGE;
            end
            5'd15:
            begin
                state_next.acc  = acc_cont;
                state_next.year = acc_cont[11:0];
                if (!is_digit)
                    err = tpr_pkg::ST_CONVERSION;
                else if (tpr_pkg::out_of_range(acc_cont, tpr_pkg::YEAR_MIN, tpr_pkg::YEAR_MAX))
                    err = tpr_pkg::ST_RANGE;
            end
            5'd16, 5'd17, 5'd22, 5'd23:
            begin
                if (char_byte != tpr_pkg::CH_SPACE)
                    err = tpr_pkg::ST_SPACES;
            end
            5'd18, 5'd19, 5'd20, 5'd21:
            begin
                // comment field: four digits or four blanks
                if (char_byte == tpr_pkg::CH_SPACE)
                begin
                    state_next.blank_count = state.blank_count + 3'd1;
                    state_next.acc = (state.position == 5'd18) ? 14'd0 : acc_x10;
                end
                else
                begin
                    state_next.acc = (state.position == 5'd18) ? acc_first : acc_cont;
                    if (!is_digit)
                        err = tpr_pkg::ST_CONVERSION;
                end
                if (state.position == 5'd21)
                begin
                    if (state_next.blank_count == tpr_pkg::BLANK_ALL)
                        state_next.comment = 14'd0;
                    else
                    begin
                        state_next.comment = state_next.acc;
                        if (err == tpr_pkg::ST_OK)
                        begin
                            if (state_next.blank_count != 3'd0)
                                err = tpr_pkg::ST_CONVERSION;
                            else if (tpr_pkg::out_of_range(state_next.acc,
                                                          tpr_pkg::COMMENT_MIN,
                                                          tpr_pkg::COMMENT_MAX))
                                err = tpr_pkg::ST_RANGE;
                        end
                    end
                end
            end
            5'd25:
            begin
                state_next.acc  = acc_cont;
                state_next.hour = acc_cont[4:0];
                if (!is_digit)
                    err = tpr_pkg::ST_CONVERSION;
                else if (acc_cont > tpr_pkg::HOUR_MAX)
                    err = tpr_pkg::ST_RANGE;
            end
            5'd26:
            begin
                if (char_byte != time_sep)
                    err = tpr_pkg::ST_TIME_SEP;
            end
            5'd28:
            begin
                state_next.acc = acc_cont;
                if (!is_digit)
                    err = tpr_pkg::ST_CONVERSION;
                else if (acc_cont > tpr_pkg::MINUTE_MAX)
                    err = tpr_pkg::ST_RANGE;
            end
            5'd29:
            begin
                if (char_byte == tpr_pkg::CH_CR)
                    state_next.cr_seen = 1'b1;
                else if (char_byte != tpr_pkg::CH_LF)
                    err = tpr_pkg::ST_NEWLINE;
            end
            5'd30:
            begin
                if (!(state.cr_seen && (char_byte == tpr_pkg::CH_LF)))
                    err = tpr_pkg::ST_NEWLINE;
            end
            default:
            begin
                err = tpr_pkg::ST_OK;
            end
        endcase

        // keep the first error of the line
        fe_next = (state.first_error != tpr_pkg::ST_OK) ? state.first_error : err;
        state_next.first_error = fe_next;

        // saturating byte count
        if (state.position != tpr_pkg::POS_MAX)
            state_next.position = state.position + 5'd1;
    end

    // line status by priority
    always_comb
    begin
        if ((date_sep == 8'd0) || (time_sep == 8'd0))
            st = tpr_pkg::ST_BAD_SETTING;
        else if (state_next.hash_seen)
            st = tpr_pkg::ST_COMMENT;
        else if ((state.position != tpr_pkg::POS_LAST_LF) &&
                 (state.position != tpr_pkg::POS_LAST_CRLF))
            st = tpr_pkg::ST_LENGTH;
        else if ((state.position == tpr_pkg::POS_LAST_LF) && state_next.cr_seen &&
                 (fe_next == tpr_pkg::ST_OK))
            st = tpr_pkg::ST_NEWLINE;
        else
            st = fe_next;
    end

    // result fields, zero unless the line is good
    always_comb
    begin
        result        = '0;
        result.status = st;
        if (st == tpr_pkg::ST_OK)
        begin
            result.punch_out      = state_next.out_flag;
            result.month_value    = state_next.month;
            result.day_value      = state_next.day;
            result.year_value     = state_next.year;
            result.comment_number = state_next.comment;
            result.hour_value     = state_next.hour;
            result.minute_value   = state_next.acc[5:0];
        end
    end

endmodule

>>> hdl/tpr_res_fifo.sv
// tpr_res_fifo: two-entry result queue that decouples the parser from the output stall
// depends on tpr_pkg
`timescale 1ns / 1ps

module tpr_res_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tpr_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output tpr_pkg::result_t out_data
);

    tpr_pkg::result_t entry_reg [2];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (!push && pop)
            count_next = count_reg - 2'd1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hdl/time_punch_record_parser_top.sv
// time_punch_record_parser_top: byte stream in, one parsed record per line out
// depends on tpr_pkg, tpr_step, tpr_res_fifo
//
// Usage:
// - s_axis carries one byte of a punch record per transfer in tdata[7:0];
//   tlast marks the final byte of the line. Only the last byte of a line
//   produces a result on m_axis.
// - m_axis tdata carries status, punch_out, month, day, year, comment number,
//   hour and minute, packed from bit 0 up; fields are zero unless status is 0.
// - The APB port holds the date separator (address 0) and time separator
//   (address 4); write them only while no line is in flight.
// Timing: a byte is held in the input register and its line state is
// updated as the byte leaves it; the result of a last byte is written from
// the input register into the result queue and is then valid on m_axis.
// Throughput: one byte per cycle unless a last byte meets a full queue, set by the single
// input register feeding the one-step parser and the two-entry result queue.
// Stall: bytes that end no line keep flowing while m_axis stalls; a last
// byte waits in the input register while the queue is full and tready drops.
// Reset: clears the line state, the queue and the separators to '/' and ':'.
`timescale 1ns / 1ps

module time_punch_record_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,   // line_end
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [3:0] status, [4] punch_out, [8:5] month_value,
                                        // [13:9] day_value, [25:14] year_value,
                                        // [39:26] comment_number, [44:40] hour_value,
                                        // [50:45] minute_value, [55:51] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 fire;
    logic                 s_accept;
    logic                 cfg_write;
    logic [7:0]           date_sep_reg;
    logic [7:0]           time_sep_reg;
    tpr_pkg::line_state_t line_reg;
    tpr_pkg::line_state_t line_next;
    tpr_pkg::result_t     step_result;
    tpr_pkg::result_t     out_result;
    logic                 res_full;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = {24'd0, (paddr[2] == tpr_pkg::REG_TIME_SEP) ? time_sep_reg : date_sep_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_sep_reg <= tpr_pkg::DATE_SEP_RESET;
            time_sep_reg <= tpr_pkg::TIME_SEP_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == tpr_pkg::REG_DATE_SEP)
                date_sep_reg <= pwdata[7:0];
            else
                time_sep_reg <= pwdata[7:0];
        end
    end

    // input register
    assign fire          = in_valid_reg && (!in_last_reg || !res_full);
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // one byte step of the parser
    tpr_step u_step
    (
        .state      (line_reg),
        .char_byte  (in_byte_reg),
        .date_sep   (date_sep_reg),
        .time_sep   (time_sep_reg),
        .state_next (line_next),
        .result     (step_result)
    );

    // line state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_reg <= '0;
        else if (fire)
        begin
            if (in_last_reg)
                line_reg <= '0;
            else
                line_reg <= line_next;
        end
    end

    // result queue
    tpr_res_fifo u_res_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire && in_last_reg),
        .push_data (step_result),
        .full      (res_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = {{(tpr_pkg::TDATA_W - tpr_pkg::RESULT_W){1'b0}}, out_result};

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg && res_full) |-> !fire)
        else $error("result pushed into a full queue");

    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last_reg) |=> (line_reg.position == 5'd0))
        else $error("line state not cleared after last byte");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !in_last_reg && (line_reg.position == tpr_pkg::POS_MAX))
        |=> (line_reg.position == tpr_pkg::POS_MAX))
        else $error("byte position wrapped");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_result.status != tpr_pkg::ST_OK)) |-> (m_axis_tdata[55:4] == '0))
        else $error("fields not zero on an error status");

endmodule

>>> tb/sv/time_punch_record_parser_top_tb.sv
// time_punch_record_parser_top_tb: self-checking bench for the punch record parser
// drives record bytes and apb separator writes, predicts each line result and checks m_axis
// depends on tpr_pkg and time_punch_record_parser_top
`timescale 1ns / 1ps

module time_punch_record_parser_top_tb;

    localparam int CYCLE_LIMIT = 200000;

    // record characters
    localparam logic [7:0] CHR_HASH  = "#";
    localparam logic [7:0] CHR_SPACE = " ";
    localparam logic [7:0] CHR_ZERO  = "0";
    localparam logic [7:0] CHR_NINE  = "9";
    localparam logic [7:0] CHR_I     = "I";
    localparam logic [7:0] CHR_N     = "N";
    localparam logic [7:0] CHR_O     = "O";
    localparam logic [7:0] CHR_U     = "U";
    localparam logic [7:0] CHR_T     = "T";
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;

    // comment field kinds
    localparam int NOTE_BLANK = -1;
    localparam int NOTE_MIXED = -2;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } stream_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    time_punch_record_parser_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    stream_byte_t      byte_stream[$];
    stream_byte_t      next_byte;
    logic [7:0]        line_buf[$];
    tpr_pkg::result_t  parsed_records[$];
    tpr_pkg::result_t  want_rec;
    tpr_pkg::result_t  got_rec;
    tpr_pkg::result_t  new_rec;
    logic              new_has;
    logic              in_taken = 1'b0;
    int                in_gap = 0;
    int                out_gap = 0;
    int                idle_pct = 0;
    int                fault_count = 0;
    int                cycle_count = 0;

    // separator settings as the parser should hold them
    logic [7:0]   cfg_date_sep = 8'd47;
    logic [7:0]   cfg_time_sep = 8'd58;

    // per-line parser state
    logic [4:0]        line_pos = '0;
    tpr_pkg::status_t  first_err = tpr_pkg::ST_OK;
    logic              hash_seen = 1'b0;
    logic              punch_flag = 1'b0;
    logic [13:0]       acc_q = '0;
    logic [3:0]        month_q = '0;
    logic [4:0]        day_q = '0;
    logic [11:0]       year_q = '0;
    logic [13:0]       comment_q = '0;
    logic [4:0]        hour_q = '0;
    logic [2:0]        blank_cnt = '0;
    logic              cr_seen = 1'b0;

    task automatic report_fault(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        fault_count++;
    endtask

    task automatic note_error(input tpr_pkg::status_t code);
        if (first_err == tpr_pkg::ST_OK)
            first_err = code;
    endtask

    task automatic add_digit(input logic [7:0] ch, input logic first);
        int d;
        d = 0;
        if (ch >= CHR_ZERO && ch <= CHR_NINE)
            d = int'(ch - CHR_ZERO);
        else
            note_error(tpr_pkg::ST_CONVERSION);
        acc_q = 14'((first ? 0 : int'(acc_q)) * 10 + d);
    endtask

    task automatic check_range(input int lo, input int hi);
        if (int'(acc_q) < lo || int'(acc_q) > hi)
            note_error(tpr_pkg::ST_RANGE);
    endtask

    // advance the line state by one byte; a last byte yields the line record
    task automatic parse_byte(input logic [7:0] ch, input logic last,
                              output logic has_rec, output tpr_pkg::result_t rec);
        logic [4:0]        p;
        tpr_pkg::status_t  st;
        p = line_pos;
        case (p)
            0:
            begin
                if (ch == CHR_HASH)
                    hash_seen = 1'b1;
                if (ch == CHR_I)
                    punch_flag = 1'b0;
                else if (ch == CHR_O)
                    punch_flag = 1'b1;
                else
                    note_error(tpr_pkg::ST_IN_OUT);
            end
            1: if (ch != (punch_flag ? CHR_U : CHR_N)) note_error(tpr_pkg::ST_IN_OUT);
            2: if (ch != (punch_flag ? CHR_T : CHR_SPACE)) note_error(tpr_pkg::ST_IN_OUT);
            3, 4, 5: if (ch != CHR_SPACE) note_error(tpr_pkg::ST_IN_OUT);
            6, 9, 12, 24, 27: add_digit(ch, 1'b1);
            7:
            begin
                add_digit(ch, 1'b0);
                check_range(1, 12);
                month_q = acc_q[3:0];
            end
            8, 11: if (ch != cfg_date_sep) note_error(tpr_pkg::ST_DATE_SEP);
            10:
            begin
                add_digit(ch, 1'b0);
                check_range(1, 31);
                day_q = acc_q[4:0];
            end
            13, 14: add_digit(ch, 1'b0);
            15:
            begin
                add_digit(ch, 1'b0);
                check_range(1900, 2200);
                year_q = acc_q[11:0];
            end
            16, 17, 22, 23: if (ch != CHR_SPACE) note_error(tpr_pkg::ST_SPACES);
            18, 19, 20, 21:
            begin
                if (ch == CHR_SPACE)
                begin
                    blank_cnt = blank_cnt + 3'd1;
                    acc_q = (p == 18) ? 14'd0 : 14'(int'(acc_q) * 10);
                end
                else
                    add_digit(ch, p == 18);
                // all blank means no comment
                if (p == 21)
                begin
                    if (blank_cnt == 3'd4)
                        comment_q = '0;
                    else
                    begin
                        if (blank_cnt != 3'd0)
                            note_error(tpr_pkg::ST_CONVERSION);
                        check_range(1000, 9999);
                        comment_q = acc_q;
                    end
                end
            end
            25:
            begin
                add_digit(ch, 1'b0);
                check_range(0, 23);
                hour_q = acc_q[4:0];
            end
            26: if (ch != cfg_time_sep) note_error(tpr_pkg::ST_TIME_SEP);
            28:
            begin
                add_digit(ch, 1'b0);
                check_range(0, 59);
            end
            29:
            begin
                if (ch == CHR_CR)
                    cr_seen = 1'b1;
                else if (ch != CHR_LF)
                    note_error(tpr_pkg::ST_NEWLINE);
            end
            30: if (!(cr_seen && ch == CHR_LF)) note_error(tpr_pkg::ST_NEWLINE);
            default: ;
        endcase

        if (line_pos != 5'd31)
            line_pos = line_pos + 5'd1;

        has_rec = last;
        rec = '0;
        if (last)
        begin
            // status priority: setting, hash, length, then first field error
            if (cfg_date_sep == 8'd0 || cfg_time_sep == 8'd0)
                st = tpr_pkg::ST_BAD_SETTING;
            else if (hash_seen)
                st = tpr_pkg::ST_COMMENT;
            else if (p != 5'd29 && p != 5'd30)
                st = tpr_pkg::ST_LENGTH;
            else
            begin
                if (p == 5'd29 && cr_seen)
                    note_error(tpr_pkg::ST_NEWLINE);
                st = first_err;
            end
            rec.status = st;
            if (st == tpr_pkg::ST_OK)
            begin
                rec.punch_out = punch_flag;
                rec.month_value = month_q;
                rec.day_value = day_q;
                rec.year_value = year_q;
                rec.comment_number = comment_q;
                rec.hour_value = hour_q;
                rec.minute_value = acc_q[5:0];
            end
            line_pos = '0;
            first_err = tpr_pkg::ST_OK;
            hash_seen = 1'b0;
            punch_flag = 1'b0;
            acc_q = '0;
            month_q = '0;
            day_q = '0;
            year_q = '0;
            comment_q = '0;
            hour_q = '0;
            blank_cnt = '0;
            cr_seen = 1'b0;
        end
    endtask

    // input byte transfers feed the predictor, output transfers are checked
    always @(posedge clk)
    begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            parse_byte(s_axis_tdata, s_axis_tlast, new_has, new_rec);
            if (new_has)
                parsed_records.push_back(new_rec);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_rec = tpr_pkg::result_t'(m_axis_tdata[tpr_pkg::RESULT_W-1:0]);
            if (parsed_records.size() == 0)
                report_fault("record with none pending, status", got_rec.status, 0);
            else
            begin
                want_rec = parsed_records.pop_front();
                if (got_rec.status !== want_rec.status)
                    report_fault("status", got_rec.status, want_rec.status);
                if (got_rec.punch_out !== want_rec.punch_out)
                    report_fault("punch_out", got_rec.punch_out, want_rec.punch_out);
                if (got_rec.month_value !== want_rec.month_value)
                    report_fault("month", got_rec.month_value, want_rec.month_value);
                if (got_rec.day_value !== want_rec.day_value)
                    report_fault("day", got_rec.day_value, want_rec.day_value);
                if (got_rec.year_value !== want_rec.year_value)
                    report_fault("year", got_rec.year_value, want_rec.year_value);
                if (got_rec.comment_number !== want_rec.comment_number)
                    report_fault("comment", got_rec.comment_number, want_rec.comment_number);
                if (got_rec.hour_value !== want_rec.hour_value)
                    report_fault("hour", got_rec.hour_value, want_rec.hour_value);
                if (got_rec.minute_value !== want_rec.minute_value)
                    report_fault("minute", got_rec.minute_value, want_rec.minute_value);
            end
        end
    end

    // byte sender with random idle bursts
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (in_gap != 0)
            begin
                in_gap <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (byte_stream.size() != 0 && idle_pct != 0 &&
                     $urandom_range(99) < idle_pct)
            begin
                in_gap <= $urandom_range(12, 0);
                s_axis_tvalid <= 1'b0;
            end
            else if (byte_stream.size() != 0)
            begin
                next_byte = byte_stream.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_byte.ch;
                s_axis_tlast <= next_byte.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver with random stall bursts
    always @(negedge clk)
    begin
        if (out_gap != 0)
        begin
            out_gap <= out_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            out_gap <= $urandom_range(12, 0);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[time_punch_record_parser_top] ERROR");
            $finish;
        end
    end

    // apb write of one separator, then read it back
    task automatic write_sep(input logic idx, input logic [7:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == tpr_pkg::REG_TIME_SEP)
            cfg_time_sep = value;
        else
            cfg_date_sep = value;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[7:0] !== value)
            report_fault("prdata", prdata[7:0], value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_number(input int value, input int digits);
        int i;
        int j;
        int div;
        for (i = digits - 1; i >= 0; i--)
        begin
            div = 1;
            for (j = 0; j < i; j++)
                div = div * 10;
            line_buf.push_back(8'(int'(CHR_ZERO) + (value / div) % 10));
        end
    endtask

    // well-formed record with the given content
    task automatic build_record(input logic punch, input int mon, input int dy, input int yr,
                                input int note, input int hr, input int mi, input logic crlf);
        int i;
        line_buf.delete();
        if (punch)
        begin
            line_buf.push_back(CHR_O);
            line_buf.push_back(CHR_U);
            line_buf.push_back(CHR_T);
        end
        else
        begin
            line_buf.push_back(CHR_I);
            line_buf.push_back(CHR_N);
            line_buf.push_back(CHR_SPACE);
        end
        repeat (3) line_buf.push_back(CHR_SPACE);
        push_number(mon, 2);
        line_buf.push_back(cfg_date_sep);
        push_number(dy, 2);
        line_buf.push_back(cfg_date_sep);
        push_number(yr, 4);
        repeat (2) line_buf.push_back(CHR_SPACE);
        if (note == NOTE_BLANK)
            repeat (4) line_buf.push_back(CHR_SPACE);
        else if (note == NOTE_MIXED)
        begin
            for (i = 0; i < 4; i++)
                line_buf.push_back($urandom_range(1) ? CHR_SPACE
                                                      : 8'(int'(CHR_ZERO) + $urandom_range(9)));
        end
        else
            push_number(note, 4);
        repeat (2) line_buf.push_back(CHR_SPACE);
        push_number(hr, 2);
        line_buf.push_back(cfg_time_sep);
        push_number(mi, 2);
        if (crlf)
            line_buf.push_back(CHR_CR);
        line_buf.push_back(CHR_LF);
    endtask

    // move the built line to the sender, last byte flagged
    task automatic flush_line();
        stream_byte_t sb;
        int i;
        for (i = 0; i < line_buf.size(); i++)
        begin
            sb.ch = line_buf[i];
            sb.last = (i == line_buf.size() - 1);
            byte_stream.push_back(sb);
        end
        line_buf.delete();
    endtask

    function automatic int pick(input int lo, input int hi, input int top);
        if ($urandom_range(9) == 0)
            pick = $urandom_range(top, 0);
        else
            pick = $urandom_range(hi, lo);
    endfunction

    // mostly valid records with random content, the rest damaged or noise
    task automatic random_line();
        int r;
        int note;
        int k;
        int n;
        r = $urandom_range(99);
        k = $urandom_range(9);
        note = (k < 4) ? NOTE_BLANK : (k == 9) ? NOTE_MIXED : pick(1000, 9999, 9999);
        build_record($urandom_range(1), pick(1, 12, 99), pick(1, 31, 99), pick(1900, 2200, 9999),
                     note, pick(0, 23, 99), pick(0, 59, 99), $urandom_range(1));
        if (r >= 55 && r < 80)
        begin
            // one damaged byte
            k = $urandom_range(line_buf.size() - 1);
            line_buf[k] = $urandom_range(1) ? 8'($urandom_range(255))
                                             : 8'(int'(CHR_ZERO) + $urandom_range(9));
        end
        else if (r >= 80 && r < 87)
        begin
            // cut short
            k = $urandom_range(line_buf.size() - 1, 1);
            while (line_buf.size() > k)
                void'(line_buf.pop_back());
        end
        else if (r >= 87 && r < 92)
        begin
            // overlong, can run the position into saturation
            n = $urandom_range(10, 1);
            repeat (n) line_buf.push_back(8'($urandom_range(255)));
        end
        else if (r >= 92 && r < 95)
            line_buf[0] = CHR_HASH;
        else if (r >= 95)
        begin
            line_buf.delete();
            n = $urandom_range(40, 1);
            repeat (n) line_buf.push_back(8'($urandom_range(255)));
            if ($urandom_range(3) == 0)
                line_buf[0] = CHR_HASH;
        end
        flush_line();
    endtask

    task automatic wait_drained();
        while (byte_stream.size() != 0 || s_axis_tvalid || parsed_records.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] date_sep, input logic [7:0] time_sep,
                             input int pct, input int lines);
        wait_drained();
        write_sep(tpr_pkg::REG_DATE_SEP, date_sep);
        write_sep(tpr_pkg::REG_TIME_SEP, time_sep);
        idle_pct = pct;
        repeat (lines) random_line();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hash line, lone zero and all-ones bytes, extreme records
        idle_pct = 20;
        line_buf.push_back(CHR_HASH);
        line_buf.push_back(CHR_LF);
        flush_line();
        line_buf.push_back(8'h00);
        flush_line();
        line_buf.push_back(8'hFF);
        flush_line();
        build_record(1'b1, 12, 31, 2200, 9999, 23, 59, 1'b1);
        flush_line();
        build_record(1'b0, 1, 1, 1900, NOTE_BLANK, 0, 0, 1'b0);
        flush_line();
        repeat (6) random_line();

        run_phase("-", ".", 0, 6);
        run_phase(8'd255, 8'd1, 35, 6);
        run_phase(8'd0, ":", 10, 3);
        run_phase("/", 8'd0, 15, 3);
        run_phase(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)), 25, 6);
        // closing stretch without idling
        run_phase("/", ":", 0, 8);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("[time_punch_record_parser_top] OK");
        else
            $display("[time_punch_record_parser_top] ERROR");
        $finish;
    end

endmodule

>>> sim.f
hdl/tpr_pkg.sv
hdl/tpr_step.sv
hdl/tpr_res_fifo.sv
hdl/time_punch_record_parser_top.sv
tb/sv/time_punch_record_parser_top_tb.sv
